### hdl/tss_pkg.sv
// Shared types, codes and arithmetic helpers for the sliding Theil-Sen line fit.
package tss_pkg;

	localparam int WINDOW_POINTS_DEF = 8;

	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic               func;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic [3:0]         points_held;
	} out_item_t;

	typedef struct packed {
		logic               clear;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_LD,
		ST_DIV_RUN,
		ST_DIV_SAT,
		ST_DIV_WR2,
		ST_COL_RD,
		ST_COL_WR,
		ST_SEL_LD,
		ST_SEL_SCAN,
		ST_SEL_FIN,
		ST_MUL,
		ST_ISUB,
		ST_OUT
	} eng_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/tss_front.sv
// Front end: accepts input beats, classifies them and queues commands for the engine.
module tss_front import tss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	cmd_t       cmd_in;

	assign item_ready = (fill_q != 2'd2);
	assign cmd_valid  = (fill_q != 2'd0);
	assign cmd        = fifo_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = cmd_valid && cmd_ready;

	always_comb begin
		cmd_in.clear = (item.func == FUNC_CLEAR);
		cmd_in.x     = item.point_x;
		cmd_in.y     = item.point_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### hdl/tss_back.sv
// Engine: window update, serial pair-slope division, rank-select medians, result register.
module tss_back import tss_pkg::*; #(
	parameter int WINDOW_POINTS = WINDOW_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	localparam int SW    = (WINDOW_POINTS > 1) ? $clog2(WINDOW_POINTS) : 1;
	localparam int CW    = $clog2(WINDOW_POINTS + 1);
	localparam int PAIRS = WINDOW_POINTS * (WINDOW_POINTS - 1) / 2;
	localparam int SD    = (PAIRS > WINDOW_POINTS) ? PAIRS : WINDOW_POINTS;
	localparam int SAW   = $clog2(SD);
	localparam int SDW   = $clog2(SD + 1);
	localparam int MD    = WINDOW_POINTS * WINDOW_POINTS;
	localparam int MAW   = $clog2(MD);
	localparam logic [SW:0]   NS       = (SW + 1)'(WINDOW_POINTS);
	localparam logic [CW-1:0] NC       = CW'(WINDOW_POINTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_POINTS - 1);

	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
		input logic [CW-1:0] k);
		logic [SW:0] sum;
		sum = {1'b0, base} + {1'b0, k[SW-1:0]};
		if (sum >= NS) begin
			sum = sum - NS;
		end
		return sum[SW-1:0];
	endfunction

	function automatic logic [MAW-1:0] pair_addr(input logic [SW-1:0] r,
		input logic [SW-1:0] c);
		return MAW'(int'(r) * WINDOW_POINTS + int'(c));
	endfunction

	eng_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [SW-1:0] oldest_q;

	logic signed [31:0] win_x_q [WINDOW_POINTS];
	logic signed [31:0] win_y_q [WINDOW_POINTS];
	logic signed [31:0] slope_mem [MD];
	logic signed [31:0] scr_mem [SD];

	logic [SW-1:0]  slot_q, s_q;
	logic [CW-1:0]  a_q, ca_q, cb_q;
	logic [48:0]    num_q, quo_q;
	logic [32:0]    den_q, rem_q;
	logic           neg_q;
	logic [5:0]     step_q;
	logic signed [31:0] pslope_q, slope_rd_q, scr_a_q, scr_b_q;
	logic signed [31:0] lo_q, hi_q, slope_q;
	logic [SDW-1:0] n_q, sel_n_q, i_q, j_q, jr_q, lt_q, eqb_q;
	logic           phase_int_q;
	logic signed [63:0] prod_s1;
	out_item_t      res_q;

	logic           full;
	logic [SW-1:0]  push_slot, s_cur;
	logic [CW-1:0]  push_cnt;
	logic signed [32:0] dx, dy;
	logic [32:0]    adx, ady;
	logic [33:0]    rem_sh;
	logic           q_bit;
	logic [48:0]    quo_neg;
	logic signed [31:0] div_val;
	logic [MAW-1:0] col_addr;
	logic           div_more, col_last, isub_last;
	logic [SDW-1:0] lt_n, eq_n, pos, mid;
	logic           scan_last;
	logic signed [32:0] med_sum;
	logic signed [31:0] med;
	logic signed [63:0] prod_sh;
	logic signed [31:0] prod_sat, icpt_val;
	logic signed [32:0] diff;

	always_comb begin
		full      = (count_q == NC);
		push_slot = full ? oldest_q : slot_of(oldest_q, count_q);
		push_cnt  = full ? count_q : count_q + CW'(1);
		s_cur     = slot_of(oldest_q, a_q);
		dx        = {win_x_q[slot_q][31], win_x_q[slot_q]} - {win_x_q[s_cur][31], win_x_q[s_cur]};
		dy        = {win_y_q[slot_q][31], win_y_q[slot_q]} - {win_y_q[s_cur][31], win_y_q[s_cur]};
		adx       = dx[32] ? 33'(-dx) : 33'(dx);
		ady       = dy[32] ? 33'(-dy) : 33'(dy);
		rem_sh    = {rem_q, num_q[48]};
		q_bit     = (rem_sh >= {1'b0, den_q});
		quo_neg   = 49'd0 - quo_q;
		if (neg_q) begin
			div_val = (quo_q > 49'h0_8000_0000) ? 32'sh80000000 : quo_neg[31:0];
		end else begin
			div_val = (quo_q > 49'h0_7fff_ffff) ? 32'sh7fffffff : quo_q[31:0];
		end
		col_addr  = pair_addr(slot_of(oldest_q, ca_q), slot_of(oldest_q, cb_q));
		div_more  = ({1'b0, a_q} + (CW + 1)'(2)) < {1'b0, count_q};
		col_last  = ({1'b0, cb_q} + (CW + 1)'(1) == {1'b0, count_q}) &&
			({1'b0, ca_q} + (CW + 1)'(2) == {1'b0, count_q});
		isub_last = ({1'b0, a_q} + (CW + 1)'(1) == {1'b0, count_q});
		lt_n      = lt_q + SDW'(scr_b_q < scr_a_q);
		eq_n      = eqb_q + SDW'((scr_b_q == scr_a_q) && (jr_q < i_q));
		pos       = lt_n + eq_n;
		mid       = sel_n_q >> 1;
		scan_last = (jr_q + SDW'(1) == sel_n_q);
		med_sum   = {lo_q[31], lo_q} + {hi_q[31], hi_q};
		med       = sel_n_q[0] ? hi_q : med_sum[32:1];
		prod_sh   = prod_s1 >>> 16;
		prod_sat  = sat32(prod_sh);
		diff      = {win_y_q[s_cur][31], win_y_q[s_cur]} - {prod_sat[31], prod_sat};
		icpt_val  = sat32(64'(diff));
	end

	always_comb begin
		state_d      = state_q;
		cmd_ready    = (state_q == ST_IDLE);
		result_valid = (state_q == ST_OUT);
		result       = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = (!cmd.clear && push_cnt >= CW'(2)) ? ST_DIV_LD : ST_OUT;
				end
			end
			ST_DIV_LD:   state_d = (dx == 33'sd0) ? ST_DIV_SAT : ST_DIV_RUN;
			ST_DIV_RUN:  state_d = (step_q == 6'd0) ? ST_DIV_SAT : ST_DIV_RUN;
			ST_DIV_SAT:  state_d = ST_DIV_WR2;
			ST_DIV_WR2:  state_d = div_more ? ST_DIV_LD : ST_COL_RD;
			ST_COL_RD:   state_d = ST_COL_WR;
			ST_COL_WR:   state_d = col_last ? ST_SEL_LD : ST_COL_RD;
			ST_SEL_LD:   state_d = ST_SEL_SCAN;
			ST_SEL_SCAN: begin
				if (scan_last) begin
					state_d = (i_q + SDW'(1) == sel_n_q) ? ST_SEL_FIN : ST_SEL_LD;
				end
			end
			ST_SEL_FIN:  state_d = phase_int_q ? ST_OUT : ST_MUL;
			ST_MUL:      state_d = ST_ISUB;
			ST_ISUB:     state_d = isub_last ? ST_SEL_LD : ST_MUL;
			ST_OUT:      state_d = result_ready ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			oldest_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_valid) begin
				if (cmd.clear) begin
					count_q  <= '0;
					oldest_q <= '0;
				end else begin
					count_q <= push_cnt;
					if (full) begin
						oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + SW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slope_rd_q <= slope_mem[col_addr];
		scr_a_q    <= scr_mem[i_q[SAW-1:0]];
		scr_b_q    <= scr_mem[j_q[SAW-1:0]];
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.clear) begin
						res_q <= '0;
					end else begin
						win_x_q[push_slot] <= cmd.x;
						win_y_q[push_slot] <= cmd.y;
						slot_q <= push_slot;
						a_q    <= '0;
						res_q.slope       <= '0;
						res_q.intercept   <= '0;
						res_q.points_held <= 4'(push_cnt);
					end
				end
			end
			ST_DIV_LD: begin
				s_q    <= s_cur;
				neg_q  <= dx[32] ^ dy[32];
				num_q  <= {ady, 16'd0};
				den_q  <= adx;
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= 6'd48;
			end
			ST_DIV_RUN: begin
				rem_q  <= q_bit ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
				quo_q  <= {quo_q[47:0], q_bit};
				num_q  <= {num_q[47:0], 1'b0};
				step_q <= step_q - 6'd1;
			end
			ST_DIV_SAT: begin
				pslope_q <= div_val;
				slope_mem[pair_addr(s_q, slot_q)] <= div_val;
			end
			ST_DIV_WR2: begin
				slope_mem[pair_addr(slot_q, s_q)] <= pslope_q;
				a_q  <= a_q + CW'(1);
				ca_q <= '0;
				cb_q <= CW'(1);
				n_q  <= '0;
			end
			ST_COL_WR: begin
				scr_mem[n_q[SAW-1:0]] <= slope_rd_q;
				n_q <= n_q + SDW'(1);
				if ({1'b0, cb_q} + (CW + 1)'(1) == {1'b0, count_q}) begin
					ca_q <= ca_q + CW'(1);
					cb_q <= ca_q + CW'(2);
				end else begin
					cb_q <= cb_q + CW'(1);
				end
				if (col_last) begin
					sel_n_q     <= n_q + SDW'(1);
					phase_int_q <= 1'b0;
					i_q         <= '0;
					j_q         <= '0;
				end
			end
			ST_SEL_LD: begin
				lt_q  <= '0;
				eqb_q <= '0;
				jr_q  <= j_q;
				j_q   <= j_q + SDW'(1);
			end
			ST_SEL_SCAN: begin
				lt_q  <= lt_n;
				eqb_q <= eq_n;
				jr_q  <= j_q;
				if (scan_last) begin
					if (pos == mid) begin
						hi_q <= scr_a_q;
					end
					if (pos + SDW'(1) == mid) begin
						lo_q <= scr_a_q;
					end
					i_q <= i_q + SDW'(1);
					j_q <= '0;
				end else begin
					j_q <= j_q + SDW'(1);
				end
			end
			ST_SEL_FIN: begin
				if (phase_int_q) begin
					res_q.slope     <= slope_q;
					res_q.intercept <= med;
				end else begin
					slope_q <= med;
					a_q     <= '0;
				end
			end
			ST_MUL: begin
				prod_s1 <= 64'(slope_q) * 64'(win_x_q[s_cur]);
			end
			ST_ISUB: begin
				scr_mem[SAW'(a_q)] <= icpt_val;
				a_q <= a_q + CW'(1);
				if (isub_last) begin
					sel_n_q     <= SDW'(count_q);
					phase_int_q <= 1'b1;
					i_q         <= '0;
					j_q         <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/theil_sen_sliding_regression.sv
// Top level of the sliding-window Theil-Sen line fit: front queue, engine, checks.
// Timing: a clear, or a push that leaves fewer than two points, goes straight to the result;
// a push with n points uses the one-bit-a-cycle divider for the new point against the other
// n-1, gathers the P = n*(n-1)/2 pair slopes and rank-selects slope and intercept medians.
// Throughput: one item at a time in the engine; a two-beat queue takes input meanwhile.
// Reset: asynchronous, empties the window and the queue; point and slope stores keep contents.
module theil_sen_sliding_regression import tss_pkg::*; #(
	parameter int WINDOW_POINTS = WINDOW_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	tss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	tss_back #(
		.WINDOW_POINTS (WINDOW_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (WINDOW_POINTS > 15) || (result.points_held <= 4'(WINDOW_POINTS)))
		else $error("points_held beyond window size");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (WINDOW_POINTS < 16) && (result.points_held < 4'd2)
		|-> (result.slope == 32'sd0) && (result.intercept == 32'sd0))
		else $error("nonzero fit with fewer than two points");

	a_engine_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !cmd_ready)
		else $error("engine took a command while a result waits");

endmodule
